/* rtl/cbad_pkg.sv */
// ----------------------------------------------------------------------------
// cbad_pkg
// Shared types and constants of the CPU bus address decoder: target codes,
// request kinds, memory map boundaries and the control word that travels
// from the decoder to the pipeline.
// ----------------------------------------------------------------------------
package cbad_pkg;

    // Default size of the internal work RAM in bytes.
    localparam int RAM_BYTES_DEF = 2048;

    // Local store sizes, fixed by the memory map.
    localparam int PIC_REGS = 8;
    localparam int IO_BYTES = 32;

    // Request kinds carried on the input beat.
    localparam logic [1:0] REQ_READ  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_WORD  = 2'd2;

    // Memory map boundaries and special addresses.
    localparam logic [15:0] PIC_BASE     = 16'h2000;
    localparam logic [15:0] IO_BASE      = 16'h4000;
    localparam logic [15:0] IO_READ_LAST = 16'h4019;
    localparam logic [15:0] CART_BASE    = 16'h4020;
    localparam logic [15:0] DMA_ADDR     = 16'h4014;
    localparam logic [15:0] PAD1_ADDR    = 16'h4016;
    localparam logic [15:0] PAD2_ADDR    = 16'h4017;
    localparam logic [15:0] ZP_LAST      = 16'h00FF;

    // Picture registers that are served by the device on a byte read.
    localparam logic [2:0] PIC_STATUS   = 3'd2;
    localparam logic [2:0] PIC_OAM_DATA = 3'd4;
    localparam logic [2:0] PIC_DATA     = 3'd7;

    // Controller port numbers.
    localparam logic [2:0] PORT_ONE = 3'd1;
    localparam logic [2:0] PORT_TWO = 3'd2;

    typedef enum logic [2:0] {
        TGT_RAM     = 3'd0,
        TGT_LOCAL   = 3'd1,
        TGT_PICTURE = 3'd2,
        TGT_CTRL    = 3'd3,
        TGT_DMA     = 3'd4,
        TGT_CART    = 3'd5
    } cbad_target_t;

    typedef struct packed {
        cbad_target_t target;
        logic [2:0]   reg_index;
        logic [15:0]  mapped_address;
        logic         device_write;
        logic         mem_write;
        logic         rd_lo;
        logic         rd_hi;
    } cbad_ctrl_t;

endpackage

/* rtl/cbad_ram.sv */
// ----------------------------------------------------------------------------
// cbad_ram
// Generic synchronous RAM: one write port and two read ports, read data
// registered and held while the read enable is low.
// ----------------------------------------------------------------------------
module cbad_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

/* rtl/cbad_decode.sv */
// ----------------------------------------------------------------------------
// cbad_decode
// Address mirroring and target selection for one bus access. Produces the
// control word of the access and the memory indexes of its low and high
// byte in the unified store (work RAM, then picture shadows, then I/O bytes).
// ----------------------------------------------------------------------------
module cbad_decode #(
    parameter int RAM_BYTES = cbad_pkg::RAM_BYTES_DEF
) (
    input  logic [1:0]                   req_type,
    input  logic [15:0]                  bus_address,
    input  logic                         zero_page_wrap,
    output cbad_pkg::cbad_ctrl_t         ctrl,
    output logic [$clog2(RAM_BYTES + cbad_pkg::PIC_REGS + cbad_pkg::IO_BYTES)-1:0] lo_idx,
    output logic [$clog2(RAM_BYTES + cbad_pkg::PIC_REGS + cbad_pkg::IO_BYTES)-1:0] hi_idx
);

    localparam int DEPTH = RAM_BYTES + cbad_pkg::PIC_REGS + cbad_pkg::IO_BYTES;
    localparam int IW    = $clog2(DEPTH);
    // Quotient bits needed to fold any address below 0x2000 into the RAM.
    localparam int QB    = $clog2((8192 + RAM_BYTES - 1) / RAM_BYTES);

    // Restoring reduction by the constant RAM size, one quotient bit a step.
    function automatic logic [13:0] ram_mod(input logic [12:0] a);
        logic [13:0] r;
        r = {1'b0, a};
        for (int i = QB - 1; i >= 0; i--)
        begin
            if (r >= 14'(RAM_BYTES << i))
            begin
                r = r - 14'(RAM_BYTES << i);
            end
        end
        return r;
    endfunction

    logic          is_write;
    logic          is_word;
    logic          is_ram;
    logic          is_pic;
    logic [13:0]   ram_off;
    logic [2:0]    n;
    logic [15:0]   mapped;
    logic [IW-1:0] ram_idx;
    logic [IW-1:0] pic_idx;
    logic [IW-1:0] io_idx;
    logic [IW-1:0] ram_hi;
    logic          ram_hi_ok;
    logic          wrap;

    always_comb
    begin
        is_write = (req_type == cbad_pkg::REQ_WRITE);
        is_word  = (req_type == cbad_pkg::REQ_WORD);
        is_ram   = (bus_address < cbad_pkg::PIC_BASE);
        is_pic   = !is_ram && (bus_address < cbad_pkg::IO_BASE);
        ram_off  = ram_mod(bus_address[12:0]);
        n        = bus_address[2:0];

        if (is_ram)
        begin
            mapped = {2'b00, ram_off};
        end
        else if (is_pic)
        begin
            mapped = cbad_pkg::PIC_BASE | {13'd0, n};
        end
        else
        begin
            mapped = bus_address;
        end

        ram_idx = ram_off[IW-1:0];
        pic_idx = IW'(RAM_BYTES) + IW'(n);
        io_idx  = IW'(RAM_BYTES + cbad_pkg::PIC_REGS) + IW'(bus_address[4:0]);

        // The wrapped high byte of a zero-page word read comes from byte 0.
        wrap      = zero_page_wrap && (mapped == cbad_pkg::ZP_LAST);
        ram_hi    = wrap ? '0 : ram_idx + IW'(1);
        ram_hi_ok = wrap || (ram_off != 14'(RAM_BYTES - 1));

        ctrl.target         = cbad_pkg::TGT_RAM;
        ctrl.reg_index      = 3'd0;
        ctrl.mapped_address = mapped;
        ctrl.device_write   = 1'b0;
        ctrl.mem_write      = 1'b0;
        ctrl.rd_lo          = 1'b0;
        ctrl.rd_hi          = 1'b0;
        lo_idx              = ram_idx;
        hi_idx              = ram_hi;

        if (is_write)
        begin
            if (is_ram)
            begin
                ctrl.mem_write = 1'b1;
            end
            else if (is_pic)
            begin
                ctrl.reg_index = n;
                if (n == cbad_pkg::PIC_STATUS)
                begin
                    ctrl.target    = cbad_pkg::TGT_LOCAL;
                    ctrl.mem_write = 1'b1;
                    lo_idx         = pic_idx;
                end
                else
                begin
                    ctrl.target       = cbad_pkg::TGT_PICTURE;
                    ctrl.device_write = 1'b1;
                end
            end
            else if (mapped == cbad_pkg::DMA_ADDR)
            begin
                ctrl.target       = cbad_pkg::TGT_DMA;
                ctrl.device_write = 1'b1;
            end
            else if (mapped == cbad_pkg::PAD1_ADDR)
            begin
                ctrl.target       = cbad_pkg::TGT_CTRL;
                ctrl.reg_index    = cbad_pkg::PORT_ONE;
                ctrl.device_write = 1'b1;
            end
            else if (mapped >= cbad_pkg::CART_BASE)
            begin
                ctrl.target       = cbad_pkg::TGT_CART;
                ctrl.device_write = 1'b1;
            end
            else
            begin
                ctrl.target    = cbad_pkg::TGT_LOCAL;
                ctrl.mem_write = 1'b1;
                lo_idx         = io_idx;
            end
        end
        else if (mapped > cbad_pkg::IO_READ_LAST)
        begin
            ctrl.target = cbad_pkg::TGT_CART;
        end
        else if (is_word)
        begin
            ctrl.rd_lo = 1'b1;
            if (is_ram)
            begin
                ctrl.rd_hi = ram_hi_ok;
            end
            else if (is_pic)
            begin
                ctrl.target    = cbad_pkg::TGT_LOCAL;
                ctrl.reg_index = n;
                ctrl.rd_hi     = (n != cbad_pkg::PIC_DATA);
                lo_idx         = pic_idx;
                hi_idx         = pic_idx + IW'(1);
            end
            else
            begin
                ctrl.target = cbad_pkg::TGT_LOCAL;
                ctrl.rd_hi  = 1'b1;
                lo_idx      = io_idx;
                hi_idx      = io_idx + IW'(1);
            end
        end
        else
        begin
            if (is_ram)
            begin
                ctrl.rd_lo = 1'b1;
            end
            else if (is_pic)
            begin
                ctrl.reg_index = n;
                if (n inside {cbad_pkg::PIC_STATUS, cbad_pkg::PIC_OAM_DATA,
                              cbad_pkg::PIC_DATA})
                begin
                    ctrl.target = cbad_pkg::TGT_PICTURE;
                end
                else
                begin
                    ctrl.target = cbad_pkg::TGT_LOCAL;
                    ctrl.rd_lo  = 1'b1;
                    lo_idx      = pic_idx;
                end
            end
            else if (mapped == cbad_pkg::PAD1_ADDR)
            begin
                ctrl.target    = cbad_pkg::TGT_CTRL;
                ctrl.reg_index = cbad_pkg::PORT_ONE;
            end
            else if (mapped == cbad_pkg::PAD2_ADDR)
            begin
                ctrl.target    = cbad_pkg::TGT_CTRL;
                ctrl.reg_index = cbad_pkg::PORT_TWO;
            end
            else
            begin
                ctrl.target = cbad_pkg::TGT_LOCAL;
                ctrl.rd_lo  = 1'b1;
                lo_idx      = io_idx;
            end
        end
    end

endmodule

/* rtl/cpu_bus_address_decoder.sv */
// ----------------------------------------------------------------------------
// cpu_bus_address_decoder
// Decodes CPU bus accesses against the console memory map, serves the
// internal stores from one unified RAM and forwards device accesses.
// ----------------------------------------------------------------------------
//
//  Group   Dir  tdata                                         tuser
//  s_axis  in   bus_address, write_byte                       req_type, zero_page_wrap
//  m_axis  out  reg_index, mapped_address, device_byte,       target, device_write
//               read_value
//
// One access is taken per cycle while the output is not stalled. Its result
// passes through the stage-1 and output registers. The registered RAM read
// and the control word are captured at the input beat, and the output
// register loads from them when stage 1 advances. Writes land in the RAM at
// the input beat, so the next access already reads the new byte.
// After reset a clearing pass zeroes all RAM_BYTES + 40 entries of the RAM,
// during which s_axis_tready stays low.
// A stalled output holds the pipeline; the RAM read data is held with it.
// ----------------------------------------------------------------------------
module cpu_bus_address_decoder #(
    parameter int RAM_BYTES = cbad_pkg::RAM_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [15:0] bus_address, [23:16] write_byte
    input  logic [23:0] s_axis_tdata,
    // [1:0] req_type, [2] zero_page_wrap
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [2:0] reg_index, [18:3] mapped_address, [26:19] device_byte,
    // [42:27] read_value, [47:43] zero
    output logic [47:0] m_axis_tdata,
    // [2:0] target, [3] device_write
    output logic [3:0]  m_axis_tuser
);

    localparam int DEPTH = RAM_BYTES + cbad_pkg::PIC_REGS + cbad_pkg::IO_BYTES;
    localparam int IW    = $clog2(DEPTH);

    cbad_pkg::cbad_ctrl_t dec_ctrl;
    logic [IW-1:0]        lo_idx;
    logic [IW-1:0]        hi_idx;
    logic                 accept;
    logic                 s1_adv;
    logic [7:0]           q_lo;
    logic [7:0]           q_hi;
    logic                 ram_we;
    logic [IW-1:0]        ram_waddr;
    logic [7:0]           ram_wdata;

    logic                 clear_reg;
    logic                 clear_next;
    logic [IW-1:0]        clear_cnt_reg;
    logic [IW-1:0]        clear_cnt_next;
    logic                 s1_valid_reg;
    logic                 s1_valid_next;
    cbad_pkg::cbad_ctrl_t s1_ctrl_reg;
    logic [7:0]           s1_byte_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [2:0]           out_target_reg;
    logic [2:0]           out_index_reg;
    logic [15:0]          out_addr_reg;
    logic                 out_dw_reg;
    logic [7:0]           out_byte_reg;
    logic [15:0]          out_value_reg;

    cbad_decode #(
        .RAM_BYTES (RAM_BYTES)
    ) u_decode (
        .req_type       (s_axis_tuser[1:0]),
        .bus_address    (s_axis_tdata[15:0]),
        .zero_page_wrap (s_axis_tuser[2]),
        .ctrl           (dec_ctrl),
        .lo_idx         (lo_idx),
        .hi_idx         (hi_idx)
    );

    always_comb
    begin
        s1_adv        = s1_valid_reg && (!out_valid_reg || m_axis_tready);
        s_axis_tready = !clear_reg && (!s1_valid_reg || s1_adv);
        accept        = s_axis_tvalid && s_axis_tready;

        ram_we    = clear_reg || (accept && dec_ctrl.mem_write);
        ram_waddr = clear_reg ? clear_cnt_reg : lo_idx;
        ram_wdata = clear_reg ? 8'd0 : s_axis_tdata[23:16];

        clear_cnt_next = clear_cnt_reg + IW'(1);
        clear_next     = clear_reg && (clear_cnt_reg != IW'(DEPTH - 1));

        s1_valid_next  = accept || (s1_valid_reg && !s1_adv);
        out_valid_next = s1_adv || (out_valid_reg && !m_axis_tready);
    end

    cbad_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .re      (accept),
        .raddr_a (lo_idx),
        .raddr_b (hi_idx),
        .rdata_a (q_lo),
        .rdata_b (q_hi)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_reg     <= 1'b1;
            clear_cnt_reg <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            clear_reg     <= clear_next;
            clear_cnt_reg <= clear_reg ? clear_cnt_next : clear_cnt_reg;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_ctrl_reg <= dec_ctrl;
            s1_byte_reg <= dec_ctrl.device_write ? s_axis_tdata[23:16] : 8'd0;
        end
        if (s1_adv)
        begin
            out_target_reg <= s1_ctrl_reg.target;
            out_index_reg  <= s1_ctrl_reg.reg_index;
            out_addr_reg   <= s1_ctrl_reg.mapped_address;
            out_dw_reg     <= s1_ctrl_reg.device_write;
            out_byte_reg   <= s1_byte_reg;
            out_value_reg  <= {s1_ctrl_reg.rd_hi ? q_hi : 8'd0,
                               s1_ctrl_reg.rd_lo ? q_lo : 8'd0};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, out_value_reg, out_byte_reg, out_addr_reg, out_index_reg};
    assign m_axis_tuser  = {out_dw_reg, out_target_reg};

endmodule

/* rtl/cbad_checker.sv */
// ----------------------------------------------------------------------------
// cbad_checker
// Port-level checks of the CPU bus address decoder, bound to the top level.
// ----------------------------------------------------------------------------
module cbad_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic [3:0]  m_axis_tuser
);

    logic dev_target;

    assign dev_target = (m_axis_tuser[2:0] == cbad_pkg::TGT_PICTURE)
                     || (m_axis_tuser[2:0] == cbad_pkg::TGT_CTRL)
                     || (m_axis_tuser[2:0] == cbad_pkg::TGT_DMA)
                     || (m_axis_tuser[2:0] == cbad_pkg::TGT_CART);

    // A stalled result beat keeps its contents.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result beat changed while stalled");

    // Only device targets receive a forwarded write.
    a_dev_write: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[3] |-> dev_target)
        else $error("device write to an internal target");

    // The forwarded byte is zero unless a write goes to a device.
    a_dev_byte: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[3] |-> (m_axis_tdata[26:19] == 8'd0))
        else $error("device byte set without a device write");

    // Device targets supply their own data, so no store data is returned.
    a_dev_value: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && dev_target |-> (m_axis_tdata[42:27] == 16'd0))
        else $error("store data returned for a device target");

endmodule

bind cpu_bus_address_decoder cbad_checker u_cbad_checker (.*);

/* dv/tb_cpu_bus_address_decoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cpu_bus_address_decoder
// Self-checking bench for the CPU bus address decoder. Bus accesses are
// streamed in with random gaps. A scoreboard keeps its own copy of the RAM,
// the local register store and the picture shadows, and decodes every
// accepted access against the memory map. Each output beat is then checked
// field by field against the oldest decoded access, while the output side
// stalls at random.
// ----------------------------------------------------------------------------
module tb_cpu_bus_address_decoder;

    localparam int RAM_SIZE = cbad_pkg::RAM_BYTES_DEF;
    // The fourth request code is unused and decodes as a byte read.
    localparam logic [1:0] REQ_SPARE = 2'd3;
    localparam int RANDOM_ACCESSES = 850;

    typedef struct {
        cbad_pkg::cbad_target_t target;
        logic [2:0]             reg_index;
        logic [15:0]            mapped_address;
        logic                   device_write;
        logic [7:0]             device_byte;
        logic [15:0]            read_value;
    } access_result_t;

    class bus_map_scoreboard;
        logic [7:0] ram_copy [RAM_SIZE];
        logic [7:0] io_copy [cbad_pkg::IO_BYTES];
        logic [7:0] shadow_copy [cbad_pkg::PIC_REGS];
        access_result_t decoded_q [$];
        int unsigned error_count;

        function new();
            foreach (ram_copy[i]) ram_copy[i] = 8'h00;
            foreach (io_copy[i]) io_copy[i] = 8'h00;
            foreach (shadow_copy[i]) shadow_copy[i] = 8'h00;
            error_count = 0;
        endfunction

        function int pending();
            return decoded_q.size();
        endfunction

        function logic [15:0] fold_address(logic [15:0] addr);
            if (addr < cbad_pkg::PIC_BASE)
                return 16'(addr % RAM_SIZE);
            if (addr < cbad_pkg::IO_BASE)
                return cbad_pkg::PIC_BASE + {13'd0, addr[2:0]};
            return addr;
        endfunction

        // Byte held locally at a mapped address; zero where no store lies.
        function logic [7:0] peek_store(int unsigned m);
            if (m < RAM_SIZE)
                return ram_copy[m];
            if (m >= cbad_pkg::PIC_BASE && m < cbad_pkg::PIC_BASE + cbad_pkg::PIC_REGS)
                return shadow_copy[m - cbad_pkg::PIC_BASE];
            if (m >= cbad_pkg::IO_BASE && m < cbad_pkg::IO_BASE + cbad_pkg::IO_BYTES)
                return io_copy[m - cbad_pkg::IO_BASE];
            return 8'h00;
        endfunction

        function access_result_t decode_access(logic [1:0] kind, logic [15:0] addr,
                                               logic [7:0] wbyte, logic wrap);
            access_result_t r;
            logic [15:0] m;
            logic [2:0] n;
            logic [7:0] hi;
            bit is_pic;
            m = fold_address(addr);
            is_pic = (m >= cbad_pkg::PIC_BASE) && (m < cbad_pkg::IO_BASE);
            n = is_pic ? m[2:0] : 3'd0;
            r.target = cbad_pkg::TGT_RAM;
            r.reg_index = 3'd0;
            r.mapped_address = m;
            r.device_write = 1'b0;
            r.device_byte = 8'h00;
            r.read_value = 16'h0000;
            if (kind == cbad_pkg::REQ_WRITE)
            begin
                if (m < cbad_pkg::PIC_BASE)
                begin
                    ram_copy[m] = wbyte;
                end
                else if (is_pic)
                begin
                    r.reg_index = n;
                    if (n == cbad_pkg::PIC_STATUS)
                    begin
                        r.target = cbad_pkg::TGT_LOCAL;
                        shadow_copy[n] = wbyte;
                    end
                    else
                    begin
                        r.target = cbad_pkg::TGT_PICTURE;
                        r.device_write = 1'b1;
                    end
                end
                else if (m == cbad_pkg::DMA_ADDR)
                begin
                    r.target = cbad_pkg::TGT_DMA;
                    r.device_write = 1'b1;
                end
                else if (m == cbad_pkg::PAD1_ADDR)
                begin
                    r.target = cbad_pkg::TGT_CTRL;
                    r.reg_index = cbad_pkg::PORT_ONE;
                    r.device_write = 1'b1;
                end
                else if (m >= cbad_pkg::CART_BASE)
                begin
                    r.target = cbad_pkg::TGT_CART;
                    r.device_write = 1'b1;
                end
                else
                begin
                    // Everything else up to the cartridge lands locally, the
                    // read-side gap below the cartridge included.
                    r.target = cbad_pkg::TGT_LOCAL;
                    io_copy[m[4:0]] = wbyte;
                end
            end
            else if (m > cbad_pkg::IO_READ_LAST)
            begin
                r.target = cbad_pkg::TGT_CART;
            end
            else if (kind == cbad_pkg::REQ_WORD)
            begin
                r.target = (m < cbad_pkg::PIC_BASE) ? cbad_pkg::TGT_RAM : cbad_pkg::TGT_LOCAL;
                r.reg_index = n;
                if (wrap && m == cbad_pkg::ZP_LAST)
                    hi = peek_store(0);
                else
                    hi = peek_store(int'(m) + 1);
                r.read_value = {hi, peek_store(m)};
            end
            else
            begin
                if (m < cbad_pkg::PIC_BASE)
                begin
                    r.read_value = {8'h00, peek_store(m)};
                end
                else if (is_pic)
                begin
                    r.reg_index = n;
                    if (n == cbad_pkg::PIC_STATUS || n == cbad_pkg::PIC_OAM_DATA
                        || n == cbad_pkg::PIC_DATA)
                    begin
                        r.target = cbad_pkg::TGT_PICTURE;
                    end
                    else
                    begin
                        r.target = cbad_pkg::TGT_LOCAL;
                        r.read_value = {8'h00, peek_store(m)};
                    end
                end
                else if (m == cbad_pkg::PAD1_ADDR)
                begin
                    r.target = cbad_pkg::TGT_CTRL;
                    r.reg_index = cbad_pkg::PORT_ONE;
                end
                else if (m == cbad_pkg::PAD2_ADDR)
                begin
                    r.target = cbad_pkg::TGT_CTRL;
                    r.reg_index = cbad_pkg::PORT_TWO;
                end
                else
                begin
                    r.target = cbad_pkg::TGT_LOCAL;
                    r.read_value = {8'h00, peek_store(m)};
                end
            end
            if (r.device_write)
                r.device_byte = wbyte;
            return r;
        endfunction

        function void note_access(logic [1:0] kind, logic [15:0] addr,
                                  logic [7:0] wbyte, logic wrap);
            decoded_q.push_back(decode_access(kind, addr, wbyte, wrap));
        endfunction

        task report_mismatch(string field, logic [15:0] got, logic [15:0] want);
            $display("mismatch on %s: got %0h, wanted %0h", field, got, want);
            error_count++;
        endtask

        task check_beat(logic [47:0] data, logic [3:0] user);
            access_result_t r;
            if (decoded_q.size() == 0)
            begin
                report_mismatch("unexpected beat", data[18:3], 16'h0000);
            end
            else
            begin
                r = decoded_q.pop_front();
                if (user[2:0] !== r.target)
                    report_mismatch("target", {13'd0, user[2:0]}, {13'd0, r.target});
                if (data[2:0] !== r.reg_index)
                    report_mismatch("reg_index", {13'd0, data[2:0]}, {13'd0, r.reg_index});
                if (data[18:3] !== r.mapped_address)
                    report_mismatch("mapped_address", data[18:3], r.mapped_address);
                if (user[3] !== r.device_write)
                    report_mismatch("device_write", {15'd0, user[3]}, {15'd0, r.device_write});
                if (data[26:19] !== r.device_byte)
                    report_mismatch("device_byte", {8'd0, data[26:19]}, {8'd0, r.device_byte});
                if (data[42:27] !== r.read_value)
                    report_mismatch("read_value", data[42:27], r.read_value);
            end
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic [2:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic [3:0]  m_axis_tuser;

    // While set, neither side inserts idle cycles.
    bit steady = 1'b0;
    bus_map_scoreboard sb;

    cpu_bus_address_decoder dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #10 clk = ~clk;

    // Output side: check every accepted beat, then choose the next ready.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_beat(m_axis_tdata, m_axis_tuser);
        if (!steady && $urandom_range(0, 99) < 21)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= 1'b1;
    end

    task automatic send_access(logic [1:0] kind, logic [15:0] addr,
                               logic [7:0] wbyte, logic wrap);
        while (!steady && $urandom_range(0, 99) < 21)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {wbyte, addr};
        s_axis_tuser  <= {wrap, kind};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_access(kind, addr, wbyte, wrap);
    endtask

    // Holds the input side off until every decoded access has come out.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic directed_accesses();
        send_access(cbad_pkg::REQ_WRITE, 16'h0000, 8'hA5, 1'b0);
        send_access(cbad_pkg::REQ_WRITE, 16'h1FFF, 8'h5A, 1'b1);
        send_access(cbad_pkg::REQ_READ,  16'h0800, 8'hFF, 1'b0);
        // The high byte of a word at the top of RAM lies outside every store.
        send_access(cbad_pkg::REQ_WORD,  16'h07FF, 8'h00, 1'b0);
        send_access(cbad_pkg::REQ_WRITE, 16'h00FF, 8'h3C, 1'b0);
        send_access(cbad_pkg::REQ_WORD,  16'h00FF, 8'h00, 1'b1);
        send_access(cbad_pkg::REQ_WORD,  16'h00FF, 8'h00, 1'b0);
        send_access(cbad_pkg::REQ_WRITE, 16'h2002, 8'h81, 1'b0);
        send_access(cbad_pkg::REQ_WRITE, 16'h3FFB, 8'h44, 1'b0);
        send_access(cbad_pkg::REQ_READ,  16'h2002, 8'h00, 1'b0);
        send_access(cbad_pkg::REQ_READ,  16'h2004, 8'h00, 1'b0);
        send_access(cbad_pkg::REQ_READ,  16'h3FFF, 8'h00, 1'b0);
        send_access(cbad_pkg::REQ_READ,  16'h2001, 8'h00, 1'b0);
        send_access(cbad_pkg::REQ_WORD,  16'h2001, 8'h00, 1'b0);
        send_access(cbad_pkg::REQ_WORD,  16'h2007, 8'h00, 1'b1);
        send_access(cbad_pkg::REQ_WRITE, 16'h4014, 8'hFF, 1'b0);
        send_access(cbad_pkg::REQ_WRITE, 16'h4016, 8'h01, 1'b0);
        send_access(cbad_pkg::REQ_READ,  16'h4016, 8'h00, 1'b0);
        send_access(cbad_pkg::REQ_READ,  16'h4017, 8'h00, 1'b0);
        send_access(cbad_pkg::REQ_WRITE, 16'h4017, 8'h77, 1'b0);
        send_access(cbad_pkg::REQ_WORD,  16'h4016, 8'h00, 1'b0);
        // A write below the cartridge lands locally, a read there does not.
        send_access(cbad_pkg::REQ_WRITE, 16'h401A, 8'h12, 1'b0);
        send_access(cbad_pkg::REQ_READ,  16'h401A, 8'h00, 1'b0);
        send_access(cbad_pkg::REQ_WORD,  16'h4019, 8'h00, 1'b0);
        send_access(cbad_pkg::REQ_WRITE, 16'hFFFF, 8'h00, 1'b1);
        send_access(REQ_SPARE,           16'h4020, 8'h00, 1'b0);
    endtask

    task automatic random_access();
        logic [1:0]  kind;
        logic [15:0] addr;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            kind = cbad_pkg::REQ_WRITE;
        else if (pick < 70)
            kind = cbad_pkg::REQ_READ;
        else if (pick < 95)
            kind = cbad_pkg::REQ_WORD;
        else
            kind = REQ_SPARE;
        // Most addresses fall in small windows so that reads hit earlier writes.
        pick = $urandom_range(0, 99);
        if (pick < 30)
        begin
            addr = $urandom_range(0, 1) ? 16'($urandom_range(0, 63))
                                        : 16'($urandom_range(16'h07C0, 16'h07FF));
            addr = addr + 16'($urandom_range(0, 3) * RAM_SIZE);
        end
        else if (pick < 45)
        begin
            addr = 16'($urandom_range(16'h00F8, 16'h0100));
        end
        else if (pick < 65)
        begin
            addr = 16'($urandom_range(16'h2000, 16'h3FFF));
        end
        else if (pick < 85)
        begin
            addr = 16'($urandom_range(16'h4000, 16'h4027));
        end
        else
        begin
            addr = 16'($urandom);
        end
        send_access(kind, addr, 8'($urandom), 1'($urandom));
    endtask

    initial
    begin
        sb = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        directed_accesses();
        drain_results();
        for (int i = 0; i < RANDOM_ACCESSES; i++)
        begin
            steady = (i >= 300 && i < 450);
            if (i == 600)
                drain_results();
            random_access();
        end
        steady = 1'b0;
        drain_results();
        repeat (8) @(posedge clk);
        if (sb.error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("FAILURE");
        $finish;
    end

endmodule
